[hw/rtl/lpc_pkg.sv]
`default_nettype none

package lpc_pkg;

   // cache geometry
   localparam int SETS  = 64;
   localparam int WAYS  = 8;
   localparam int SET_W = $clog2(SETS);
   localparam int AGE_W = $clog2(WAYS);
   localparam int ROW_W = WAYS * AGE_W;

   // fixed field widths of the channels
   localparam int IDX_FIELD_W  = 6;
   localparam int MASK_FIELD_W = 8;
   localparam int VICTIM_W     = 3;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 8;

   // command queue depth
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request kinds carried on tuser
   localparam logic REQ_ACCESS = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef logic [WAYS-1:0][AGE_W-1:0] age_row_type;

   // classified request handed from the front end to the back end
   typedef struct packed {
      logic             query;
      logic [SET_W-1:0] set;
      logic             hit;
      logic [AGE_W-1:0] hit_way;
      logic [WAYS-1:0]  clean;
   } lpc_cmd_type;

   // age row of a set that was never written: way j holds age j
   function automatic age_row_type reset_row();
      age_row_type r;
      for (int j = 0; j < WAYS; j++) begin
         r[j] = AGE_W'(j);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/lpc_ram.sv]
`default_nettype none

module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lpc_front.sv]
`default_nettype none

module lpc_front
   import lpc_pkg::*;
(
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      lpc_cmd_type           q_cmd
);

   logic [IDX_FIELD_W-1:0]  set_index;
   logic [MASK_FIELD_W-1:0] hit_mask;
   logic [MASK_FIELD_W-1:0] clean_mask;

   assign set_index  = req_tdata[IDX_FIELD_W-1:0];
   assign hit_mask   = req_tdata[IDX_FIELD_W +: MASK_FIELD_W];
   assign clean_mask = req_tdata[IDX_FIELD_W+MASK_FIELD_W +: MASK_FIELD_W];

   // take a word whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // classify: lowest matching way, masks cut to the implemented ways
   always_comb begin
      q_cmd.query   = (req_tuser == REQ_QUERY);
      q_cmd.set     = SET_W'(set_index);
      q_cmd.hit     = 1'b0;
      q_cmd.hit_way = '0;
      for (int j = WAYS - 1; j >= 0; j--) begin
         if (j < MASK_FIELD_W && hit_mask[j]) begin
            q_cmd.hit     = 1'b1;
            q_cmd.hit_way = AGE_W'(j);
         end
      end
      for (int j = 0; j < WAYS; j++) begin
         q_cmd.clean[j] = (j < MASK_FIELD_W) ? clean_mask[j] : 1'b0;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lpc_fifo.sv]
`default_nettype none

module lpc_fifo
   import lpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire lpc_cmd_type push_cmd,
   output      logic        full,
   input  wire logic        pop,
   output      logic        pop_vld,
   output      lpc_cmd_type pop_cmd
);

   lpc_cmd_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign pop_vld = (count_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lpc_back.sv]
`default_nettype none

module lpc_back
   import lpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  prefer_clean,
   input  wire logic                  q_vld,
   input  wire lpc_cmd_type           q_cmd,
   output      logic                  q_pop,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   // execute stage
   logic        b_vld_ff, b_vld_in;
   lpc_cmd_type b_cmd_ff;
   logic        b_byp_ff, b_byp_in;
   logic        b_rowvld_ff;
   age_row_type wb_row_ff;
   logic        set_vld_ff [SETS];

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [VICTIM_W-1:0] rsp_victim_ff;
   logic                rsp_hit_ff;

   logic                out_free;
   logic                b_done;
   logic                issue;
   logic                wr;
   logic [ROW_W-1:0]    ram_rdata;
   age_row_type         row;
   age_row_type         new_row;
   logic [AGE_W-1:0]    cur_age;
   logic [AGE_W-1:0]    lru_way;
   logic [AGE_W-1:0]    clean_way;
   logic [AGE_W-1:0]    best_age;
   logic                clean_found;
   logic [AGE_W-1:0]    victim;

   lpc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (wr),
      .wr_addr (b_cmd_ff.set),
      .wr_data (new_row),
      .rd_en   (issue),
      .rd_addr (q_cmd.set),
      .rd_data (ram_rdata)
   );

   // handshake between queue, execute stage and result register
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign b_done   = b_vld_ff && out_free;
   assign issue    = q_vld && (!b_vld_ff || b_done);
   assign q_pop    = issue;
   assign wr       = b_done && !b_cmd_ff.query && b_cmd_ff.hit;

   // current ages: just-written row, stored row, or the reset row
   always_comb begin
      if (b_byp_ff) begin
         row = wb_row_ff;
      end else if (b_rowvld_ff) begin
         row = age_row_type'(ram_rdata);
      end else begin
         row = reset_row();
      end
   end

   // hit update: ages above the hit way's age drop by one, hit way becomes newest
   always_comb begin
      cur_age = row[b_cmd_ff.hit_way];
      for (int j = 0; j < WAYS; j++) begin
         if (AGE_W'(j) == b_cmd_ff.hit_way) begin
            new_row[j] = AGE_W'(WAYS - 1);
         end else if (row[j] > cur_age) begin
            new_row[j] = row[j] - 1'b1;
         end else begin
            new_row[j] = row[j];
         end
      end
   end

   // victim: age-0 way, or the oldest clean way in prefer-clean mode
   always_comb begin
      lru_way     = '0;
      clean_way   = '0;
      best_age    = '0;
      clean_found = 1'b0;
      for (int j = WAYS - 1; j >= 0; j--) begin
         if (row[j] == '0) begin
            lru_way = AGE_W'(j);
         end
      end
      for (int j = 0; j < WAYS; j++) begin
         if (b_cmd_ff.clean[j] && (!clean_found || row[j] < best_age)) begin
            clean_found = 1'b1;
            clean_way   = AGE_W'(j);
            best_age    = row[j];
         end
      end
      victim = (prefer_clean && clean_found) ? clean_way : lru_way;
   end

   // next state of the control flags
   always_comb begin
      b_vld_in = b_vld_ff;
      if (issue) begin
         b_vld_in = 1'b1;
      end else if (b_done) begin
         b_vld_in = 1'b0;
      end
      b_byp_in   = wr && (q_cmd.set == b_cmd_ff.set);
      rsp_vld_in = rsp_vld_ff;
      if (b_done) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int s = 0; s < SETS; s++) begin
            set_vld_ff[s] <= 1'b0;
         end
      end else begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (wr) begin
            set_vld_ff[b_cmd_ff.set] <= 1'b1;
         end
      end
      if (issue) begin
         b_cmd_ff    <= q_cmd;
         b_byp_ff    <= b_byp_in;
         b_rowvld_ff <= set_vld_ff[q_cmd.set];
      end
      if (wr) begin
         wb_row_ff <= new_row;
      end
      if (b_done) begin
         rsp_victim_ff <= b_cmd_ff.query ? VICTIM_W'(victim) : '0;
         rsp_hit_ff    <= !b_cmd_ff.query && b_cmd_ff.hit;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_hit_ff, rsp_victim_ff});

endmodule

`default_nettype wire

[hw/rtl/lru_prefer_clean_replacement.sv]
// LRU replacement state for a set-associative cache, with a prefer-clean
// victim rule. Each set holds one age per way; age 0 is least recent.
// Request channel (req_): tuser selects access update (0) or eviction
// query (1); tdata carries the set index, the per-way hit mask and the
// per-way clean mask. An access with a hit makes the lowest matching way
// newest; an eviction query returns a victim way without changing state.
// Response channel (rsp_): one word per request, with the victim way
// (0 on accesses) and the hit flag.
// csr_wr_en/csr_wr_data write the prefer_clean bit; write it only while
// no request is in flight.
// A request passes the command queue, execute stage and response
// register before rsp_tvalid rises. Throughput: one request per cycle
// while rsp_tready is high; the age memory is read at issue, written
// back after a hit, and bypassed for a back-to-back same-set request.
// Reset clears prefer_clean and marks every set's row as unwritten, so it
// reads as way j holding age j; no clearing pass is needed.
// When the receiver stalls, the response register holds its word and the
// two-entry command queue absorbs requests until it fills, then req_tready
// drops.
`default_nettype none

module lru_prefer_clean_replacement
   import lpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [5:0] set_index, [13:6] hit_mask, [21:14] clean_mask, [23:22] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  wire logic                  req_tuser,
   // response channel
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] victim_way, [3] hit, [7:4] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   logic        prefer_clean_ff, prefer_clean_in;
   logic        q_push;
   logic        q_full;
   lpc_cmd_type push_cmd;
   logic        q_pop;
   logic        q_vld;
   lpc_cmd_type pop_cmd;

   // prefer_clean register
   assign prefer_clean_in = csr_wr_en ? csr_wr_data : prefer_clean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefer_clean_ff <= 1'b0;
      end else begin
         prefer_clean_ff <= prefer_clean_in;
      end
   end

   lpc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   lpc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_vld  (q_vld),
      .pop_cmd  (pop_cmd)
   );

   lpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .prefer_clean (prefer_clean_ff),
      .q_vld        (q_vld),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire
